// ----- sv/dqs_pkg.sv -----
// Package for the double-ended queue with search.
// Holds the depth, derived widths, command and status codes, and the cell
// operation struct. No dependencies.
`timescale 1ns / 1ps

package dqs_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_SEARCH     = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} dqs_op_t;

endpackage

// ----- sv/dqs_cell.sv -----
// One storage cell of the queue chain: an entry, its valid bit and a
// search flag that ripples toward the back of the chain.
// Depends on dqs_pkg.
`timescale 1ns / 1ps

module dqs_cell
	import dqs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dqs_op_t            op,
	input  logic signed [31:0] push_value,
	input  logic signed [31:0] key,
	input  logic signed [31:0] left_data,
	input  logic               left_valid,
	input  logic signed [31:0] right_data,
	input  logic               right_valid,
	input  logic               found_in,
	output logic signed [31:0] data,
	output logic               valid,
	output logic               found_out
);

	logic signed [31:0] data_q;
	logic               valid_q;
	logic               found_q;
	logic               load_back;

	// The first empty cell behind the last held entry takes a push at the back.
	assign load_back = op.push_back && left_valid && !valid_q;

	always_ff @(posedge clk) begin
		if (op.push_front) begin
			data_q <= left_data;
		end else if (op.pop_front) begin
			data_q <= right_data;
		end else if (load_back) begin
			data_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (op.push_front) begin
				valid_q <= left_valid;
			end else if (op.pop_front) begin
				valid_q <= right_valid;
			end else if (op.push_back) begin
				valid_q <= valid_q | left_valid;
			end else if (op.pop_back) begin
				valid_q <= valid_q & right_valid;
			end
			found_q <= found_in | (valid_q && (data_q == key));
		end
	end

	assign data      = data_q;
	assign valid     = valid_q;
	assign found_out = found_q;

endmodule

// ----- sv/deque_with_search_unit.sv -----
// Results: a push, a pop or an unused command gives its result in the cycle after
// acceptance; a search first registers its key, waits in S_SEARCH while the found
// flag ripples through the DEPTH cells one cell per cycle, then reports from S_FINISH.
// Throughput: one push or pop per cycle while results are taken at once; a search
// holds the input until its result is given.
// Reset: arst_n clears the count, the valid bits and the control; entries stay.
`timescale 1ns / 1ps

module deque_with_search_unit
	import dqs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               found,
	output logic [4:0]         count
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   srch_cnt_q;
	logic signed [31:0] key_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [CNT_W-1:0]   count_q;

	logic               accept;
	logic               is_full;
	logic               is_empty;
	dqs_op_t            op;

	logic signed [31:0] data_w  [DEPTH];
	logic [DEPTH-1:0]   valid_w;
	logic [DEPTH-1:0]   found_w;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		op = '0;
		if (accept) begin
			op.push_front = (command == CMD_PUSH_FRONT) && !is_full;
			op.push_back  = (command == CMD_PUSH_BACK) && !is_full;
			op.pop_front  = (command == CMD_POP_FRONT) && !is_empty;
			op.pop_back   = (command == CMD_POP_BACK) && !is_empty;
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [31:0] left_data;
		logic               left_valid;
		logic signed [31:0] right_data;
		logic               right_valid;
		logic               found_in;

		if (k == 0) begin : g_head
			assign left_data  = value;
			assign left_valid = 1'b1;
			assign found_in   = 1'b0;
		end else begin : g_mid
			assign left_data  = data_w[k-1];
			assign left_valid = valid_w[k-1];
			assign found_in   = found_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign right_data  = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_data  = data_w[k+1];
			assign right_valid = valid_w[k+1];
		end

		dqs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.push_value  (value),
			.key         (key_q),
			.left_data   (left_data),
			.left_valid  (left_valid),
			.right_data  (right_data),
			.right_valid (right_valid),
			.found_in    (found_in),
			.data        (data_w[k]),
			.valid       (valid_w[k]),
			.found_out   (found_w[k])
		);
	end

	always_ff @(posedge clk) begin
		if (accept && (command == CMD_SEARCH)) begin
			key_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			srch_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
			found_q     <= 1'b0;
			count_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_SEARCH)) begin
						out_valid_q <= 1'b0;
						srch_cnt_q  <= '0;
						state_q     <= S_SEARCH;
					end else if (accept) begin
						out_valid_q <= 1'b1;
						found_q     <= 1'b0;
						if (op.push_front || op.push_back) begin
							status_q <= ST_DONE;
							cnt_q    <= cnt_q + CNT_W'(1);
							count_q  <= cnt_q + CNT_W'(1);
						end else if (op.pop_front || op.pop_back) begin
							status_q <= ST_DONE;
							cnt_q    <= cnt_q - CNT_W'(1);
							count_q  <= cnt_q - CNT_W'(1);
						end else if ((command == CMD_PUSH_FRONT) ||
								(command == CMD_PUSH_BACK)) begin
							status_q <= ST_FULL;
							count_q  <= cnt_q;
						end else if ((command == CMD_POP_FRONT) ||
								(command == CMD_POP_BACK)) begin
							status_q <= ST_EMPTY;
							count_q  <= cnt_q;
						end else begin
							status_q <= ST_DONE;
							count_q  <= cnt_q;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_SEARCH: begin
					srch_cnt_q <= srch_cnt_q + IDX_W'(1);
					if (srch_cnt_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					out_valid_q <= 1'b1;
					status_q    <= ST_DONE;
					found_q     <= found_w[DEPTH-1];
					count_q     <= cnt_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign count     = 5'(count_q);

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(cnt_q))
		else $error("cell valid bits disagree with the entry count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the depth");

	a_push_back_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == CMD_PUSH_BACK) && !is_full)
		|=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("push at the back did not add an entry");

	a_no_shift_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (op == '0))
		else $error("cells changed while a search was running");

endmodule
